@@ hw/rtl/gcp_pkg.sv @@
// Shared widths and helpers for the gesture cursor projector.
// No dependencies.
`default_nettype none
package gcp_pkg;
  localparam int unsigned QW    = 16;   // Q1.15 cursor width
  localparam int unsigned DW    = 33;   // divider operand width
  localparam int unsigned RW    = 34;   // divider partial remainder width
  localparam int unsigned SW    = 34;   // signed sum width
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CHKCF  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_THRESH = 3'd2;
  localparam logic [CFG_AW-1:0] REG_LEFT   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_TOP    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_RIGHT  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_BOTTOM = 3'd6;

  localparam logic [8:0] CONF_HALF = 9'd128;

  function automatic logic signed [SW-1:0] sx(input logic signed [31:0] v);
    sx = {{(SW-32){v[31]}}, v};
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/gcp_div.sv @@
// Pipelined restoring divider: q = floor(num * 2^15 / den), num <= den.
// One quotient bit per stage; depends on gcp_pkg.
`default_nettype none
module gcp_div
  import gcp_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [DW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic [QW-1:0]      quo_o
);
  logic [RW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [RW-1:0] trial;
    logic [RW-1:0] dext;
    logic [DW-1:0] dsel;
    logic [QW-1:0] qprev;
    logic          bit_d;
    if (i == 0) begin : g_first
      assign trial = {{(RW-DW){1'b0}}, num_i};
      assign dsel  = den_i;
      assign qprev = '0;
    end else begin : g_next
      assign trial = {rem_q[i-1][RW-2:0], 1'b0};
      assign dsel  = den_q[i-1];
      assign qprev = quo_q[i-1];
    end
    assign dext  = {{(RW-DW){1'b0}}, dsel};
    assign bit_d = trial >= dext;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= bit_d ? trial - dext : trial;
        den_q[i] <= dsel;
        quo_q[i] <= {qprev[QW-2:0], bit_d};
      end
    end
  end

  assign quo_o = quo_q[QW-1];
endmodule
`default_nettype wire

@@ hw/rtl/gesture_cursor_projector_unit.sv @@
// Gesture cursor projector: one hand beat in, one cursor beat out, every cycle while the sink is ready.
// The pipeline has three arithmetic stages (differences, products, sums and
// range checks) followed by a 16-stage divider that retires one quotient bit per
// stage, one lane per axis. The pipeline advances whenever the output register is
// empty or taken, so a new beat is accepted each cycle while the sink is ready.
// Depends on gcp_pkg and gcp_div.
`default_nettype none
module gesture_cursor_projector_unit
  import gcp_pkg::*;
#(
  parameter int unsigned FRAME_WIDTH  = 640,
  parameter int unsigned FRAME_HEIGHT = 480
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_AW-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0] cfg_data_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // user_id, hand_x, hand_y, hand_z, ref_x, ref_y, ref_z,
  // hand_confidence, ref_confidence, pixel_x, pixel_y
  input  wire logic [135:0]      s_axis_tdata,
  // hand_side
  input  wire logic              s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // user_out, cursor_action, cursor_x, cursor_y, zero fill
  output logic [39:0]            m_axis_tdata,
  // side_out
  output logic                   m_axis_tuser
);
  localparam logic signed [12:0] FW_S = 13'(FRAME_WIDTH);
  localparam logic signed [12:0] FH_S = 13'(FRAME_HEIGHT);
  localparam logic [DW-1:0] FW_D = DW'(FRAME_WIDTH);
  localparam logic [DW-1:0] FH_D = DW'(FRAME_HEIGHT);

  // config
  logic               mode_q, chk_q;
  logic [15:0]        thr_q;
  logic signed [14:0] left_q, top_q, right_q, bottom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      chk_q    <= 1'b1;
      thr_q    <= 16'd400;
      left_q   <= -15'sd3100;
      top_q    <= 15'sd2650;
      right_q  <= 15'sd2000;
      bottom_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:   mode_q   <= cfg_data_i[0];
        REG_CHKCF:  chk_q    <= cfg_data_i[0];
        REG_THRESH: thr_q    <= cfg_data_i;
        REG_LEFT:   left_q   <= cfg_data_i[14:0];
        REG_TOP:    top_q    <= cfg_data_i[14:0];
        REG_RIGHT:  right_q  <= cfg_data_i[14:0];
        REG_BOTTOM: bottom_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // unpack
  logic [3:0]         in_user;
  logic signed [14:0] hx, hy, hz, rx, ry, rz;
  logic [8:0]         hc, rc;
  logic signed [11:0] px, py;
  assign in_user = s_axis_tdata[3:0];
  assign hx = s_axis_tdata[18:4];
  assign hy = s_axis_tdata[33:19];
  assign hz = s_axis_tdata[48:34];
  assign rx = s_axis_tdata[63:49];
  assign ry = s_axis_tdata[78:64];
  assign rz = s_axis_tdata[93:79];
  assign hc = s_axis_tdata[102:94];
  assign rc = s_axis_tdata[111:103];
  assign px = s_axis_tdata[123:112];
  assign py = s_axis_tdata[135:124];

  // stage 1: differences and simple checks
  logic               v1_q, conf1_q, pix1_q, side1_q;
  logic [3:0]         user1_q;
  logic signed [15:0] dx1_q, dy1_q, dz1_q, w1_q, h1_q;
  logic signed [14:0] rx1_q, ry1_q, rz1_q;
  logic [10:0]        px1_q, py1_q;
  logic signed [12:0] pxe, pye;
  assign pxe = {px[11], px};
  assign pye = {py[11], py};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      user1_q <= in_user;
      side1_q <= s_axis_tuser;
      dx1_q   <= 16'(hx) - 16'(rx);
      dy1_q   <= 16'(hy) - 16'(ry);
      dz1_q   <= 16'(hz) - 16'(rz);
      w1_q    <= 16'(right_q) - 16'(left_q);
      h1_q    <= 16'(top_q) - 16'(bottom_q);
      rx1_q   <= rx;
      ry1_q   <= ry;
      rz1_q   <= rz;
      conf1_q <= !chk_q || (hc > CONF_HALF && rc > CONF_HALF);
      pix1_q  <= pxe >= 0 && pxe <= FW_S && pye >= 0 && pye <= FH_S;
      px1_q   <= px[10:0];
      py1_q   <= py[10:0];
    end
  end

  // stage 2: products
  logic               v2_q, conf2_q, pix2_q, nz2_q, side2_q;
  logic [3:0]         user2_q;
  logic [10:0]        px2_q, py2_q;
  logic signed [31:0] sxx_q, syy_q, szz_q, rxdz_q, dxrz_q, ldz_q, tdz_q, rydz_q, dyrz_q;
  logic signed [31:0] dzw_q, dzh_q;
  logic [31:0]        thr2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      user2_q <= user1_q;
      side2_q <= side1_q;
      conf2_q <= conf1_q;
      pix2_q  <= pix1_q;
      nz2_q   <= dz1_q != 0 && w1_q != 0 && h1_q != 0;
      px2_q   <= px1_q;
      py2_q   <= py1_q;
      sxx_q   <= dx1_q * dx1_q;
      syy_q   <= dy1_q * dy1_q;
      szz_q   <= dz1_q * dz1_q;
      thr2_q  <= thr_q * thr_q;
      rxdz_q  <= rx1_q * dz1_q;
      dxrz_q  <= dx1_q * rz1_q;
      ldz_q   <= left_q * dz1_q;
      tdz_q   <= top_q * dz1_q;
      rydz_q  <= ry1_q * dz1_q;
      dyrz_q  <= dy1_q * rz1_q;
      dzw_q   <= dz1_q * w1_q;
      dzh_q   <= dz1_q * h1_q;
    end
  end

  // stage 3: sums, sign fold, range check, operand select
  logic signed [SW-1:0] dist2, nx, ny, dnx, dny, nxf, nyf, dxf, dyf;
  logic                 reach, okx, oky, ok3;
  logic [DW-1:0]        numx, numy, denx, deny;
  assign dist2 = sx(sxx_q) + sx(syy_q) + sx(szz_q);
  assign reach = dist2 >= $signed({2'b00, thr2_q});
  assign nx  = sx(rxdz_q) - sx(dxrz_q) - sx(ldz_q);
  assign ny  = sx(tdz_q) - sx(rydz_q) + sx(dyrz_q);
  assign dnx = sx(dzw_q);
  assign dny = sx(dzh_q);
  assign nxf = dnx[SW-1] ? -nx : nx;
  assign dxf = dnx[SW-1] ? -dnx : dnx;
  assign nyf = dny[SW-1] ? -ny : ny;
  assign dyf = dny[SW-1] ? -dny : dny;
  assign okx = !nxf[SW-1] && nxf <= dxf;
  assign oky = !nyf[SW-1] && nyf <= dyf;
  assign ok3 = conf2_q && reach && (mode_q ? (nz2_q && okx && oky) : pix2_q);
  assign numx = mode_q ? nxf[DW-1:0] : DW'(px2_q);
  assign numy = mode_q ? nyf[DW-1:0] : DW'(py2_q);
  assign denx = mode_q ? dxf[DW-1:0] : FW_D;
  assign deny = mode_q ? dyf[DW-1:0] : FH_D;

  logic          v3_q, ok3_q, side3_q;
  logic [3:0]    user3_q;
  logic [DW-1:0] numx_q, numy_q, denx_q, deny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      user3_q <= user2_q;
      side3_q <= side2_q;
      ok3_q   <= ok3;
      numx_q  <= ok3 ? numx : '0;
      numy_q  <= ok3 ? numy : '0;
      denx_q  <= ok3 ? denx : DW'(1);
      deny_q  <= ok3 ? deny : DW'(1);
    end
  end

  // divider lanes
  logic [QW-1:0] qx, qy;
  gcp_div u_div_x (.clk_i, .en_i(en), .num_i(numx_q), .den_i(denx_q), .quo_o(qx));
  gcp_div u_div_y (.clk_i, .en_i(en), .num_i(numy_q), .den_i(deny_q), .quo_o(qy));

  // sideband line alongside the divider
  logic       vl_q [QW];
  logic       okl_q [QW];
  logic       sidel_q [QW];
  logic [3:0] userl_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_line
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vl_q[i] <= 1'b0;
      else if (en) vl_q[i] <= (i == 0) ? v3_q : vl_q[(i == 0) ? 0 : i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        okl_q[i]   <= (i == 0) ? ok3_q   : okl_q[(i == 0) ? 0 : i-1];
        sidel_q[i] <= (i == 0) ? side3_q : sidel_q[(i == 0) ? 0 : i-1];
        userl_q[i] <= (i == 0) ? user3_q : userl_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  logic          act;
  logic [QW-1:0] cx, cy;
  assign act = okl_q[QW-1];
  assign cx  = act ? qx : '0;
  assign cy  = act ? qy : '0;

  assign m_axis_tvalid = vl_q[QW-1];
  assign m_axis_tuser  = sidel_q[QW-1];
  assign m_axis_tdata  = {3'b000, cy, cx, act, userl_q[QW-1]};

  a_remove_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[4] |-> m_axis_tdata[36:5] == '0)
    else $error("remove beat carries nonzero cursor");
  a_cursor_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[20:5] <= 16'd32768 && m_axis_tdata[36:21] <= 16'd32768)
    else $error("cursor above one");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output slot");
endmodule
`default_nettype wire

@@ tb/tb_gesture_cursor_projector_unit.sv @@
// Testbench for gesture_cursor_projector_unit: directed and random hand beats with stalls on both sides,
// a cursor predictor, and a scoreboard that checks every output beat in order.
// Depends on gcp_pkg and the block RTL.
`timescale 1ns / 100ps

module tb_gesture_cursor_projector_unit
  import gcp_pkg::*;
;

  typedef struct packed {
    logic [3:0]  user;
    logic        side;
    logic        action;
    logic [15:0] cx;
    logic [15:0] cy;
  } cursor_t;

  typedef struct {
    logic [3:0]         user;
    logic               side;
    logic signed [14:0] hx, hy, hz, rx, ry, rz;
    logic [8:0]         hc, rc;
    logic signed [11:0] px, py;
  } hand_t;

  class cursor_board;
    cursor_t pending[$];
    int      errors;
    bit      mode, chk;
    logic [15:0] thr;
    longint  left, top, right, bottom;

    function new();
      errors = 0;
      mode = 0; chk = 1; thr = 400;
      left = -3100; top = 2650; right = 2000; bottom = 0;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] idx, logic [15:0] v);
      case (idx)
        REG_MODE:   mode = v[0];
        REG_CHKCF:  chk = v[0];
        REG_THRESH: thr = v;
        REG_LEFT:   left = longint'($signed(v[14:0]));
        REG_TOP:    top = longint'($signed(v[14:0]));
        REG_RIGHT:  right = longint'($signed(v[14:0]));
        REG_BOTTOM: bottom = longint'($signed(v[14:0]));
        default: ;
      endcase
    endfunction

    function bit ratio(longint num, longint den, output longint q);
      q = 0;
      if (den < 0) begin
        den = -den; num = -num;
      end
      if (num < 0 || num > den) return 0;
      q = (num * 32768) / den;
      return 1;
    endfunction

    function void note_hand(hand_t h);
      cursor_t c;
      longint dx, dy, dz, rx, ry, rz, px, py, w, hh, nx, ny, qx, qy;
      bit ok;
      rx = h.rx; ry = h.ry; rz = h.rz; px = h.px; py = h.py;
      dx = longint'(h.hx) - rx; dy = longint'(h.hy) - ry; dz = longint'(h.hz) - rz;
      ok = 1; qx = 0; qy = 0;
      if (chk && (h.hc <= CONF_HALF || h.rc <= CONF_HALF)) ok = 0;
      if (dx*dx + dy*dy + dz*dz < longint'(thr) * longint'(thr)) ok = 0;
      if (ok && !mode) begin
        if (px < 0 || px > 640 || py < 0 || py > 480) ok = 0;
        else begin
          qx = px * 32768 / 640; qy = py * 32768 / 480;
        end
      end else if (ok) begin
        w = right - left; hh = top - bottom;
        if (dz == 0 || w == 0 || hh == 0) ok = 0;
        else begin
          nx = rx*dz - dx*rz - left*dz;
          ny = top*dz - ry*dz + dy*rz;
          if (!ratio(nx, dz*w, qx) || !ratio(ny, dz*hh, qy)) ok = 0;
        end
      end
      if (!ok) begin
        qx = 0; qy = 0;
      end
      c.user = h.user; c.side = h.side; c.action = ok;
      c.cx = qx[15:0]; c.cy = qy[15:0];
      pending.push_back(c);
    endfunction

    function void check_cursor(cursor_t got);
      cursor_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $realtime, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.user != e.user)
        $display("%0t: user expected %0d actual %0d", $realtime, e.user, got.user);
      if (got.side != e.side)
        $display("%0t: side expected %0d actual %0d", $realtime, e.side, got.side);
      if (got.action != e.action)
        $display("%0t: action expected %0d actual %0d", $realtime, e.action, got.action);
      if (got.cx != e.cx)
        $display("%0t: cursor_x expected %0d actual %0d", $realtime, e.cx, got.cx);
      if (got.cy != e.cy)
        $display("%0t: cursor_y expected %0d actual %0d", $realtime, e.cy, got.cy);
      if (got != e) errors++;
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CFG_AW-1:0] cfg_idx_i = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 0, s_axis_tuser = 0, m_axis_tready = 0;
  logic [135:0] s_axis_tdata = '0;
  logic s_axis_tready, m_axis_tvalid, m_axis_tuser;
  logic [39:0] m_axis_tdata;

  gesture_cursor_projector_unit DUT (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  cursor_board board = new();
  int idle_cycles = 0;
  bit sink_bursty = 0;
  localparam int WATCHDOG = 20000;

  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk_i) begin
    cursor_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '0;
        got.user = m_axis_tdata[3:0];
        got.side = m_axis_tuser;
        got.action = m_axis_tdata[4];
        got.cx = m_axis_tdata[20:5];
        got.cy = m_axis_tdata[36:21];
        board.check_cursor(got);
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // sink stalls
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (sink_bursty) m_axis_tready <= 1;
      else begin
        n = gap_len();
        if (n == 0) m_axis_tready <= 1;
        else begin
          m_axis_tready <= 0;
          repeat (n - 1) @(negedge clk_i);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    board.set_reg(idx, v);
  endtask

  task automatic send_hand(hand_t h);
    int n = gap_len();
    if (n > 0) begin
      s_axis_tvalid <= 0;
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= h.side;
    s_axis_tdata <= {h.py, h.px, h.rc, h.hc, h.rz, h.ry, h.rx, h.hz, h.hy, h.hx, h.user};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_hand(h);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (25) @(negedge clk_i);
  endtask

  function automatic logic signed [14:0] near(int c, int spread);
    int v = c + $urandom_range(0, 2*spread) - spread;
    if (v > 16383) v = 16383;
    if (v < -16384) v = -16384;
    return v[14:0];
  endfunction

  function automatic hand_t rand_hand(bit vec);
    hand_t h;
    int r = $urandom_range(0, 9);
    h.user = 4'($urandom); h.side = 1'($urandom);
    if (r == 0) begin
      {h.hx, h.hy, h.hz, h.rx, h.ry, h.rz} = 90'({$urandom, $urandom, $urandom});
      h.hc = 9'($urandom); h.rc = 9'($urandom);
      h.px = 12'($urandom); h.py = 12'($urandom);
      return h;
    end
    h.hc = 9'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(120, 256));
    h.rc = 9'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(120, 256));
    h.px = $urandom_range(0, 9) == 0 ? 12'($urandom) : 12'($urandom_range(0, 650) - 5);
    h.py = $urandom_range(0, 9) == 0 ? 12'($urandom) : 12'($urandom_range(0, 490) - 5);
    if (!vec) begin
      h.rx = near(0, 3000); h.ry = near(0, 3000); h.rz = near(2000, 1500);
      h.hx = near(h.rx, 800); h.hy = near(h.ry, 800); h.hz = near(h.rz, 800);
    end else begin
      h.rx = near(0, 1500); h.ry = near(1000, 1500); h.rz = near(2500, 1500);
      h.hx = near(h.rx, 600); h.hy = near(h.ry, 600);
      h.hz = near(h.rz - 500, 500);
      if ($urandom_range(0, 19) == 0) h.hz = h.rz;
    end
    return h;
  endfunction

  task automatic directed();
    hand_t h;
    h = rand_hand(0);
    h.rx = 0; h.ry = 0; h.rz = 0; h.hx = 1000; h.hy = 0; h.hz = 0;
    h.hc = 256; h.rc = 256;
    h.px = 0; h.py = 0; send_hand(h);
    h.px = 640; h.py = 480; send_hand(h);
    h.px = 641; send_hand(h);
    h.px = 320; h.py = 481; send_hand(h);
    h.px = -1; h.py = 10; send_hand(h);
    h.px = 12'h7ff; h.py = 12'h800; send_hand(h);
    h.px = 100; h.py = 100; h.hc = 128; send_hand(h);
    h.hc = 129; h.rc = 128; send_hand(h);
    h.rc = 511; h.hc = 0; send_hand(h);
    h.hc = 300; h.rc = 300; h.hx = 400; send_hand(h);
    h.hx = 399; send_hand(h);
    h.hx = 15'h3fff; h.hy = 15'h3fff; h.hz = 15'h3fff;
    h.rx = 15'h4000; h.ry = 15'h4000; h.rz = 15'h4000; h.user = 15; h.side = 1;
    send_hand(h);
    h.user = 0; h.side = 0; h.hx = 0; h.hy = 0; h.hz = 0; h.rx = 0; h.ry = 0; h.rz = 0;
    send_hand(h);
  endtask

  task automatic directed_vector();
    hand_t h;
    h = rand_hand(1);
    h.hc = 256; h.rc = 256;
    h.rx = 0; h.ry = 1500; h.rz = 2500; h.hx = 100; h.hy = 1400; h.hz = 2000;
    send_hand(h);
    h.hz = h.rz; send_hand(h);
    h.hz = 2000; h.hx = 3000; send_hand(h);
    h.hx = -100; h.hy = 2000; send_hand(h);
    h.hz = 3000; send_hand(h);
  endtask

  task automatic run_random(int n, bit vec);
    for (int i = 0; i < n; i++) send_hand(rand_hand(vec));
    drain();
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    directed();
    directed_vector();
    drain();
    write_reg(REG_CHKCF, 16'd0);
    write_reg(REG_THRESH, 16'd0);
    run_random(300, 0);
    write_reg(REG_CHKCF, 16'd1);
    write_reg(REG_THRESH, 16'hffff);
    run_random(50, 0);
    write_reg(REG_THRESH, 16'd200);
    sink_bursty = 1;
    run_random(300, 0);
    sink_bursty = 0;
    write_reg(REG_MODE, 16'd1);
    directed_vector();
    run_random(400, 1);
    write_reg(REG_LEFT, 16'h7fff);
    write_reg(REG_RIGHT, 16'h3fff);
    write_reg(REG_TOP, 16'h4000);
    write_reg(REG_BOTTOM, 16'h7fff);
    run_random(100, 1);
    write_reg(REG_LEFT, 16'd1000);
    write_reg(REG_RIGHT, 16'd1000);
    run_random(50, 1);
    write_reg(REG_LEFT, 16'h7000);
    write_reg(REG_RIGHT, 16'd3000);
    write_reg(REG_TOP, 16'd3000);
    write_reg(REG_BOTTOM, 16'd3000);
    run_random(50, 1);
    write_reg(REG_LEFT, 16'hf000);
    write_reg(REG_RIGHT, 16'd1500);
    write_reg(REG_TOP, 16'hfc18);
    write_reg(REG_BOTTOM, 16'd2500);
    write_reg(REG_CHKCF, 16'd0);
    write_reg(REG_THRESH, 16'd50);
    run_random(400, 1);
    write_reg(REG_MODE, 16'd0);
    run_random(300, 0);
    if (board.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
